FILE: rtl/idq_pkg.sv
// idq_pkg: shared constants, codes and controller/datapath structs for the
// indexed deque engine. No dependencies; every other rtl file uses it.

package idq_pkg;

	// Ring size; must be a power of two so slot arithmetic wraps by truncation.
	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = ADDR_W + 1;

	// Request field widths
	localparam int TYPE_W = 3;
	localparam int POS_W  = 6;
	localparam int NCNT_W = 7;
	localparam int STAT_W = 2;

	// count + N compares without overflow
	localparam int SUM_W  = ((CNT_W > NCNT_W) ? CNT_W : NCNT_W) + 1;

	typedef enum logic [TYPE_W-1:0] {
		REQ_SEARCH     = 3'd0,
		REQ_READ       = 3'd1,
		REQ_WRITE      = 3'd2,
		REQ_PUSH_FRONT = 3'd3,
		REQ_POP_FRONT  = 3'd4,
		REQ_PUSH_BACK  = 3'd5,
		REQ_COPY       = 3'd6,
		REQ_TAKE       = 3'd7
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_COPY_RD,
		S_COPY_WR,
		S_TAKE_RD,
		S_TAKE_OUT,
		S_EMIT
	} state_t;

	// Memory address source
	typedef enum logic [2:0] {
		A_HEAD,
		A_HEAD_M1,
		A_POS,
		A_IDX,
		A_TAIL
	} addr_sel_t;

	typedef enum logic {
		W_ITEM,
		W_RDATA
	} wr_src_t;

	// Head/count update
	typedef enum logic [2:0] {
		P_HOLD,
		P_PUSH_FRONT,
		P_PUSH_BACK,
		P_POP,
		P_TAKE
	} ptr_op_t;

	typedef struct packed {
		logic      load_req;
		logic      rd_en;
		logic      wr_en;
		addr_sel_t addr_sel;
		wr_src_t   wr_src;
		ptr_op_t   ptr_op;
		logic      idx_clr;
		logic      idx_inc;
		logic      hit_upd;
		logic      stat_load;
		status_t   stat;
		logic      out_load;
		logic      out_rd;
		logic      out_last;
	} ctrl_cmd_t;

	typedef struct packed {
		req_type_t req_type;
		logic      pos_bad;
		logic      empty;
		logic      full;
		logic      copy_over;
		logic      take_over;
		logic      cnt_zero;
		logic      idx_at_cnt;
		logic      idx_at_len;
		logic      out_free;
	} dp_status_t;

endpackage

FILE: rtl/idq_req_if.sv
// idq_req_if: request channel (valid/ready plus request payload).
// Depends on idq_pkg for field widths.

interface idq_req_if;
	logic                               valid;
	logic                               ready;
	logic [idq_pkg::TYPE_W-1:0]         req_type;
	logic [idq_pkg::POS_W-1:0]          position;
	logic signed [idq_pkg::DATA_WIDTH-1:0] item_value;
	logic [idq_pkg::NCNT_W-1:0]         item_count;

	modport source (output valid, output req_type, output position, output item_value,
		output item_count, input ready);
	modport sink (input valid, input req_type, input position, input item_value,
		input item_count, output ready);
endinterface

FILE: rtl/idq_rsp_if.sv
// idq_rsp_if: response channel (valid/ready plus result payload).
// Depends on idq_pkg for field widths.

interface idq_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [idq_pkg::DATA_WIDTH-1:0] out_value;
	logic                               found;
	logic [idq_pkg::STAT_W-1:0]         status;
	logic                               last;

	modport source (output valid, output out_value, output found, output status,
		output last, input ready);
	modport sink (input valid, input out_value, input found, input status,
		input last, output ready);
endinterface

FILE: rtl/idq_dp.sv
// idq_dp: datapath - element ring memory, head/count registers, request
// latch, walk index, search hit flag and response register. Uses idq_pkg.

module idq_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [idq_pkg::TYPE_W-1:0]         req_type,
	input  logic [idq_pkg::POS_W-1:0]          position,
	input  logic signed [idq_pkg::DATA_WIDTH-1:0] item_value,
	input  logic [idq_pkg::NCNT_W-1:0]         item_count,
	input  idq_pkg::ctrl_cmd_t                 cmd,
	output idq_pkg::dp_status_t                st,
	idq_rsp_if.source                          rsp
);

	logic [idq_pkg::DATA_WIDTH-1:0] mem [idq_pkg::CAPACITY];
	logic [idq_pkg::DATA_WIDTH-1:0] rdata_q;

	idq_pkg::req_type_t             type_q;
	logic [idq_pkg::POS_W-1:0]      pos_q;
	logic [idq_pkg::DATA_WIDTH-1:0] val_q;
	logic [idq_pkg::NCNT_W-1:0]     ncnt_q;

	logic [idq_pkg::ADDR_W-1:0]     head_q;
	logic [idq_pkg::CNT_W-1:0]      count_q;
	logic [idq_pkg::ADDR_W-1:0]     idx_q;
	logic                           hit_q;
	idq_pkg::status_t               stat_q;

	logic                           out_valid_q;
	logic [idq_pkg::DATA_WIDTH-1:0] out_value_q;
	logic                           out_found_q;
	idq_pkg::status_t               out_status_q;
	logic                           out_last_q;

	logic [idq_pkg::ADDR_W-1:0]     addr;
	logic [idq_pkg::DATA_WIDTH-1:0] wdata;
	logic                           use_rd;

	// Slot = (head + offset) mod CAPACITY via truncation
	always_comb begin
		case (cmd.addr_sel)
			idq_pkg::A_HEAD:    addr = head_q;
			idq_pkg::A_HEAD_M1: addr = head_q - idq_pkg::ADDR_W'(1);
			idq_pkg::A_POS:     addr = head_q + idq_pkg::ADDR_W'(pos_q);
			idq_pkg::A_IDX:     addr = head_q + idx_q;
			idq_pkg::A_TAIL:    addr = head_q + count_q[idq_pkg::ADDR_W-1:0];
			default:            addr = head_q;
		endcase
	end

	assign wdata = (cmd.wr_src == idq_pkg::W_RDATA) ? rdata_q : val_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q <= idq_pkg::req_type_t'(req_type);
			pos_q  <= position;
			val_q  <= item_value;
			ncnt_q <= item_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			case (cmd.ptr_op)
				idq_pkg::P_PUSH_FRONT: begin
					head_q  <= head_q - idq_pkg::ADDR_W'(1);
					count_q <= count_q + idq_pkg::CNT_W'(1);
				end
				idq_pkg::P_PUSH_BACK: begin
					count_q <= count_q + idq_pkg::CNT_W'(1);
				end
				idq_pkg::P_POP: begin
					head_q  <= head_q + idq_pkg::ADDR_W'(1);
					count_q <= count_q - idq_pkg::CNT_W'(1);
				end
				idq_pkg::P_TAKE: begin
					head_q  <= head_q + ncnt_q[idq_pkg::ADDR_W-1:0];
					count_q <= count_q - idq_pkg::CNT_W'(ncnt_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hit_q  <= 1'b0;
			stat_q <= idq_pkg::ST_OK;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + idq_pkg::ADDR_W'(1);
			end
			if (cmd.load_req) begin
				hit_q <= 1'b0;
			end else if (cmd.hit_upd) begin
				hit_q <= hit_q | (rdata_q == val_q);
			end
			if (cmd.stat_load) begin
				stat_q <= cmd.stat;
			end
		end
	end

	// Read and pop return the fetched word on success; take flags it per element
	assign use_rd = cmd.out_rd || ((stat_q == idq_pkg::ST_OK) &&
		((type_q == idq_pkg::REQ_READ) || (type_q == idq_pkg::REQ_POP_FRONT)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q  <= use_rd ? rdata_q : '0;
			out_found_q  <= hit_q;
			out_status_q <= stat_q;
			out_last_q   <= cmd.out_last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_value = out_value_q;
	assign rsp.found     = out_found_q;
	assign rsp.status    = out_status_q;
	assign rsp.last      = out_last_q;

	assign st.req_type   = type_q;
	assign st.pos_bad    = idq_pkg::CNT_W'(pos_q) >= count_q;
	assign st.empty      = count_q == '0;
	assign st.full       = count_q == idq_pkg::CNT_W'(idq_pkg::CAPACITY);
	assign st.copy_over  = (idq_pkg::SUM_W'(count_q) + idq_pkg::SUM_W'(ncnt_q)) >
		idq_pkg::SUM_W'(idq_pkg::CAPACITY);
	assign st.take_over  = idq_pkg::SUM_W'(ncnt_q) > idq_pkg::SUM_W'(count_q);
	assign st.cnt_zero   = ncnt_q == '0;
	assign st.idx_at_cnt = (idq_pkg::SUM_W'(idx_q) + idq_pkg::SUM_W'(1)) ==
		idq_pkg::SUM_W'(ncnt_q);
	assign st.idx_at_len = (idq_pkg::SUM_W'(idx_q) + idq_pkg::SUM_W'(1)) ==
		idq_pkg::SUM_W'(count_q);
	assign st.out_free   = !out_valid_q || rsp.ready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= idq_pkg::CNT_W'(idq_pkg::CAPACITY))
		else $error("element count above capacity");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ptr_op == idq_pkg::P_POP || cmd.ptr_op == idq_pkg::P_TAKE) |-> count_q != '0)
		else $error("removal from empty store");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("memory read and write in same cycle");

endmodule

FILE: rtl/idq_ctrl.sv
// idq_ctrl: request sequencer. Decodes the latched request against datapath
// status and steps walks (search, copy, take). Uses idq_pkg.

module idq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  idq_pkg::dp_status_t st,
	output idq_pkg::ctrl_cmd_t  cmd
);

	idq_pkg::state_t state_q;
	idq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			idq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = idq_pkg::S_DECODE;
				end
			end
			idq_pkg::S_DECODE: begin
				cmd.stat_load = 1'b1;
				cmd.stat      = idq_pkg::ST_OK;
				state_d       = idq_pkg::S_EMIT;
				case (st.req_type)
					idq_pkg::REQ_SEARCH: begin
						if (!st.empty) begin
							cmd.idx_clr = 1'b1;
							state_d     = idq_pkg::S_SRCH_RD;
						end
					end
					idq_pkg::REQ_READ: begin
						if (st.pos_bad) begin
							cmd.stat = idq_pkg::ST_BAD_INDEX;
						end else begin
							cmd.rd_en    = 1'b1;
							cmd.addr_sel = idq_pkg::A_POS;
						end
					end
					idq_pkg::REQ_WRITE: begin
						if (st.pos_bad) begin
							cmd.stat = idq_pkg::ST_BAD_INDEX;
						end else begin
							cmd.wr_en    = 1'b1;
							cmd.addr_sel = idq_pkg::A_POS;
							cmd.wr_src   = idq_pkg::W_ITEM;
						end
					end
					idq_pkg::REQ_PUSH_FRONT: begin
						if (st.full) begin
							cmd.stat = idq_pkg::ST_FULL;
						end else begin
							cmd.wr_en    = 1'b1;
							cmd.addr_sel = idq_pkg::A_HEAD_M1;
							cmd.wr_src   = idq_pkg::W_ITEM;
							cmd.ptr_op   = idq_pkg::P_PUSH_FRONT;
						end
					end
					idq_pkg::REQ_POP_FRONT: begin
						if (st.empty) begin
							cmd.stat = idq_pkg::ST_EMPTY;
						end else begin
							cmd.rd_en    = 1'b1;
							cmd.addr_sel = idq_pkg::A_HEAD;
							cmd.ptr_op   = idq_pkg::P_POP;
						end
					end
					idq_pkg::REQ_PUSH_BACK: begin
						if (st.full) begin
							cmd.stat = idq_pkg::ST_FULL;
						end else begin
							cmd.wr_en    = 1'b1;
							cmd.addr_sel = idq_pkg::A_TAIL;
							cmd.wr_src   = idq_pkg::W_ITEM;
							cmd.ptr_op   = idq_pkg::P_PUSH_BACK;
						end
					end
					idq_pkg::REQ_COPY: begin
						if (st.cnt_zero) begin
							cmd.stat = idq_pkg::ST_OK;
						end else if (st.empty) begin
							cmd.stat = idq_pkg::ST_EMPTY;
						end else if (st.copy_over) begin
							cmd.stat = idq_pkg::ST_FULL;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = idq_pkg::S_COPY_RD;
						end
					end
					idq_pkg::REQ_TAKE: begin
						if (st.cnt_zero) begin
							cmd.stat = idq_pkg::ST_OK;
						end else if (st.empty) begin
							cmd.stat = idq_pkg::ST_EMPTY;
						end else if (st.take_over) begin
							cmd.stat = idq_pkg::ST_BAD_INDEX;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = idq_pkg::S_TAKE_RD;
						end
					end
					default: begin
					end
				endcase
			end
			idq_pkg::S_SRCH_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = idq_pkg::A_IDX;
				state_d      = idq_pkg::S_SRCH_CMP;
			end
			idq_pkg::S_SRCH_CMP: begin
				cmd.hit_upd = 1'b1;
				if (st.idx_at_len) begin
					state_d = idq_pkg::S_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = idq_pkg::S_SRCH_RD;
				end
			end
			idq_pkg::S_COPY_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = idq_pkg::A_IDX;
				state_d      = idq_pkg::S_COPY_WR;
			end
			// Append at tail; list grows, so later reads can see copied entries
			idq_pkg::S_COPY_WR: begin
				cmd.wr_en    = 1'b1;
				cmd.addr_sel = idq_pkg::A_TAIL;
				cmd.wr_src   = idq_pkg::W_RDATA;
				cmd.ptr_op   = idq_pkg::P_PUSH_BACK;
				if (st.idx_at_cnt) begin
					state_d = idq_pkg::S_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = idq_pkg::S_COPY_RD;
				end
			end
			idq_pkg::S_TAKE_RD: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = idq_pkg::A_IDX;
				state_d      = idq_pkg::S_TAKE_OUT;
			end
			idq_pkg::S_TAKE_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_rd   = 1'b1;
					cmd.out_last = st.idx_at_cnt;
					if (st.idx_at_cnt) begin
						cmd.ptr_op = idq_pkg::P_TAKE;
						state_d    = idq_pkg::S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = idq_pkg::S_TAKE_RD;
					end
				end
			end
			idq_pkg::S_EMIT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = idq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = idq_pkg::S_IDLE;
			end
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("response overwritten before taken");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_last) |=> state_q == idq_pkg::S_IDLE)
		else $error("request not finished after last response");

	a_copy_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idq_pkg::S_COPY_WR) |-> !st.full)
		else $error("copy append into full store");

endmodule

FILE: rtl/indexed_deque_engine_core.sv
// indexed_deque_engine_core: top level of the ring-buffer deque engine.
// Depends on idq_pkg, idq_req_if, idq_rsp_if, idq_ctrl and idq_dp.
//
//   port  dir  handshake    payload
//   req   in   valid/ready  req_type, position, item_value, item_count
//   rsp   out  valid/ready  out_value, found, status, last
//
// One request at a time. Single-element requests and all error cases step
// through accept, decode and respond. Search reads and compares each element;
// copy of N reads and appends N elements; take of N reads each of N elements
// and gives one response per element. The walks are set by the single-port
// element memory with its registered read.
// A stalled response holds in the output register; the engine stops only
// when it needs to load another. Reset clears head and count; no clear pass.

module indexed_deque_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	idq_req_if.sink    req,
	idq_rsp_if.source  rsp
);

	idq_pkg::ctrl_cmd_t  cmd;
	idq_pkg::dp_status_t st;
	logic                in_ready;

	assign req.ready = in_ready;

	idq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	idq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req.req_type),
		.position   (req.position),
		.item_value (req.item_value),
		.item_count (req.item_count),
		.cmd        (cmd),
		.st         (st),
		.rsp        (rsp)
	);

endmodule

FILE: tb/deque_result_checker.sv
// deque_result_checker: watches the request and response channels of the deque
// engine, keeps its own copy of the ring contents and compares every response.
// Depends on idq_pkg, idq_req_if and idq_rsp_if.
`timescale 1ns / 1ps

module deque_result_checker (
	input  logic clk,
	input  logic arst_n,
	idq_req_if   req,
	idq_rsp_if   rsp,
	output int   error_count,
	output int   pending_results
);

	typedef struct packed {
		logic [idq_pkg::DATA_WIDTH-1:0] value;
		logic                           found;
		idq_pkg::status_t               status;
		logic                           last;
	} deque_result_t;

	deque_result_t                  expected_results[$];
	logic [idq_pkg::DATA_WIDTH-1:0] shadow_store[idq_pkg::CAPACITY];
	logic [idq_pkg::ADDR_W-1:0]     shadow_head = '0;
	int unsigned                    shadow_count = 0;
	int                             mismatches = 0;
	int                             pending = 0;

	assign error_count     = mismatches;
	assign pending_results = pending;

	function automatic logic [idq_pkg::ADDR_W-1:0] ring_slot(int unsigned offset);
		// power-of-two ring: truncation does the wrap
		return shadow_head + offset[idq_pkg::ADDR_W-1:0];
	endfunction

	task automatic report_mismatch(string what, logic [idq_pkg::DATA_WIDTH-1:0] want,
		logic [idq_pkg::DATA_WIDTH-1:0] got);
		$display("%0t ns  %s: expected %h, got %h", $time, what, want, got);
		mismatches++;
	endtask

	task automatic queue_result(logic [idq_pkg::DATA_WIDTH-1:0] value, logic found,
		idq_pkg::status_t status, logic last);
		deque_result_t r;
		r.value  = value;
		r.found  = found;
		r.status = status;
		r.last   = last;
		expected_results.push_back(r);
	endtask

	// Applies one accepted request to the shadow ring and queues its responses.
	task automatic predict_deque_results(idq_pkg::req_type_t kind,
		logic [idq_pkg::POS_W-1:0] pos, logic [idq_pkg::DATA_WIDTH-1:0] val,
		logic [idq_pkg::NCNT_W-1:0] n);
		logic        hit;
		int unsigned i;
		hit = 1'b0;
		case (kind)
			idq_pkg::REQ_SEARCH: begin
				for (i = 0; i < shadow_count; i++)
					if (shadow_store[ring_slot(i)] == val)
						hit = 1'b1;
				queue_result('0, hit, idq_pkg::ST_OK, 1'b1);
			end
			idq_pkg::REQ_READ: begin
				if (pos >= shadow_count)
					queue_result('0, 1'b0, idq_pkg::ST_BAD_INDEX, 1'b1);
				else
					queue_result(shadow_store[ring_slot(32'(pos))], 1'b0, idq_pkg::ST_OK,
						1'b1);
			end
			idq_pkg::REQ_WRITE: begin
				if (pos >= shadow_count) begin
					queue_result('0, 1'b0, idq_pkg::ST_BAD_INDEX, 1'b1);
				end else begin
					shadow_store[ring_slot(32'(pos))] = val;
					queue_result('0, 1'b0, idq_pkg::ST_OK, 1'b1);
				end
			end
			idq_pkg::REQ_PUSH_FRONT: begin
				if (shadow_count >= idq_pkg::CAPACITY) begin
					queue_result('0, 1'b0, idq_pkg::ST_FULL, 1'b1);
				end else begin
					shadow_head = shadow_head - idq_pkg::ADDR_W'(1);
					shadow_store[shadow_head] = val;
					shadow_count++;
					queue_result('0, 1'b0, idq_pkg::ST_OK, 1'b1);
				end
			end
			idq_pkg::REQ_POP_FRONT: begin
				if (shadow_count == 0) begin
					queue_result('0, 1'b0, idq_pkg::ST_EMPTY, 1'b1);
				end else begin
					queue_result(shadow_store[shadow_head], 1'b0, idq_pkg::ST_OK, 1'b1);
					shadow_head = ring_slot(1);
					shadow_count--;
				end
			end
			idq_pkg::REQ_PUSH_BACK: begin
				if (shadow_count >= idq_pkg::CAPACITY) begin
					queue_result('0, 1'b0, idq_pkg::ST_FULL, 1'b1);
				end else begin
					shadow_store[ring_slot(shadow_count)] = val;
					shadow_count++;
					queue_result('0, 1'b0, idq_pkg::ST_OK, 1'b1);
				end
			end
			idq_pkg::REQ_COPY: begin
				if (n == 0) begin
					queue_result('0, 1'b0, idq_pkg::ST_OK, 1'b1);
				end else if (shadow_count == 0) begin
					queue_result('0, 1'b0, idq_pkg::ST_EMPTY, 1'b1);
				end else if (shadow_count + n > idq_pkg::CAPACITY) begin
					queue_result('0, 1'b0, idq_pkg::ST_FULL, 1'b1);
				end else begin
					// list grows while copying, so N > count repeats the originals
					for (i = 0; i < n; i++) begin
						shadow_store[ring_slot(shadow_count)] = shadow_store[ring_slot(i)];
						shadow_count++;
					end
					queue_result('0, 1'b0, idq_pkg::ST_OK, 1'b1);
				end
			end
			default: begin
				if (n == 0) begin
					queue_result('0, 1'b0, idq_pkg::ST_OK, 1'b1);
				end else if (shadow_count == 0) begin
					queue_result('0, 1'b0, idq_pkg::ST_EMPTY, 1'b1);
				end else if (n > shadow_count || n > idq_pkg::CAPACITY) begin
					queue_result('0, 1'b0, idq_pkg::ST_BAD_INDEX, 1'b1);
				end else begin
					for (i = 0; i < n; i++)
						queue_result(shadow_store[ring_slot(i)], 1'b0, idq_pkg::ST_OK,
							i + 1 == n);
					shadow_head = ring_slot(32'(n));
					shadow_count -= n;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			shadow_head = '0;
			shadow_count = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (req.valid && req.ready)
				predict_deque_results(idq_pkg::req_type_t'(req.req_type), req.position,
					req.item_value, req.item_count);
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("response with no request outstanding", '0, rsp.out_value);
				end else begin
					want = expected_results.pop_front();
					if (rsp.out_value !== want.value)
						report_mismatch("out_value", want.value, rsp.out_value);
					if (rsp.found !== want.found)
						report_mismatch("found", idq_pkg::DATA_WIDTH'(want.found),
							idq_pkg::DATA_WIDTH'(rsp.found));
					if (rsp.status !== want.status)
						report_mismatch("status", idq_pkg::DATA_WIDTH'(want.status),
							idq_pkg::DATA_WIDTH'(rsp.status));
					if (rsp.last !== want.last)
						report_mismatch("last", idq_pkg::DATA_WIDTH'(want.last),
							idq_pkg::DATA_WIDTH'(rsp.last));
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

FILE: tb/tb.sv
// tb: top of the deque engine testbench. Drives directed and random requests,
// stalls the response side at random and reports the verdict.
// Depends on idq_pkg, idq_req_if, idq_rsp_if, the core and deque_result_checker.
`timescale 1ns / 1ps

module tb;

	logic clk;
	logic arst_n;
	int   error_count;
	int   pending_results;
	int   fill_level;
	int   item_index;
	bit   steady;

	idq_req_if req ();
	idq_rsp_if rsp ();

	indexed_deque_engine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	deque_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.error_count     (error_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Response side: random stalls, a quiet stretch, and one long hold-off.
	initial begin : responder
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && item_index >= 60) begin
				hold_left = 160;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (steady) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= 34);
			end
		end
	end

	// Offers one request, waits for it to be taken, and tracks the expected fill.
	task automatic send_request(idq_pkg::req_type_t kind, int pos,
		logic [idq_pkg::DATA_WIDTH-1:0] val, int n);
		while (!steady && $urandom_range(0, 99) < 34) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid      <= 1'b1;
		req.req_type   <= kind;
		req.position   <= pos[idq_pkg::POS_W-1:0];
		req.item_value <= val;
		req.item_count <= n[idq_pkg::NCNT_W-1:0];
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		case (kind)
			idq_pkg::REQ_PUSH_FRONT, idq_pkg::REQ_PUSH_BACK:
				if (fill_level < idq_pkg::CAPACITY) fill_level++;
			idq_pkg::REQ_POP_FRONT: if (fill_level > 0) fill_level--;
			idq_pkg::REQ_COPY: begin
				if (n > 0 && fill_level > 0 && fill_level + n <= idq_pkg::CAPACITY)
					fill_level += n;
			end
			idq_pkg::REQ_TAKE: if (n > 0 && n <= fill_level) fill_level -= n;
			default: ;
		endcase
	endtask

	initial begin : stimulus
		int                             i;
		int                             pick;
		int                             pos;
		int                             n;
		int                             room;
		bit                             filling;
		logic [idq_pkg::DATA_WIDTH-1:0] val;
		idq_pkg::req_type_t             kind;

		arst_n = 1'b0;
		steady = 1'b0;
		item_index = 0;
		fill_level = 0;
		req.valid      <= 1'b0;
		req.req_type   <= idq_pkg::REQ_SEARCH;
		req.position   <= '0;
		req.item_value <= '0;
		req.item_count <= '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty-store errors and zero-size requests
		send_request(idq_pkg::REQ_POP_FRONT, 0, '0, 0);
		send_request(idq_pkg::REQ_TAKE, 0, '0, 0);
		send_request(idq_pkg::REQ_TAKE, 0, '0, 5);
		send_request(idq_pkg::REQ_COPY, 0, '0, 0);
		send_request(idq_pkg::REQ_COPY, 0, '0, 3);
		send_request(idq_pkg::REQ_READ, 0, '0, 0);
		send_request(idq_pkg::REQ_WRITE, 0, 32'h1234_5678, 0);
		send_request(idq_pkg::REQ_SEARCH, 0, '0, 0);
		// head wraps below zero on the front push
		send_request(idq_pkg::REQ_PUSH_BACK, 0, 32'h7fff_ffff, 0);
		send_request(idq_pkg::REQ_PUSH_FRONT, 0, 32'h8000_0000, 0);
		send_request(idq_pkg::REQ_PUSH_BACK, 0, 32'hffff_ffff, 0);
		send_request(idq_pkg::REQ_READ, 2, '0, 0);
		send_request(idq_pkg::REQ_WRITE, 1, '0, 0);
		send_request(idq_pkg::REQ_SEARCH, 0, '0, 0);
		send_request(idq_pkg::REQ_SEARCH, 0, 32'd5, 0);
		// copy far beyond the count: cyclic repeat up to exactly full
		send_request(idq_pkg::REQ_COPY, 0, '0, 61);
		send_request(idq_pkg::REQ_PUSH_FRONT, 0, 32'd1, 0);
		send_request(idq_pkg::REQ_PUSH_BACK, 0, 32'd2, 0);
		send_request(idq_pkg::REQ_COPY, 0, '0, 1);
		send_request(idq_pkg::REQ_READ, 63, '0, 0);
		send_request(idq_pkg::REQ_WRITE, 63, 32'h5a5a_5a5a, 0);
		send_request(idq_pkg::REQ_SEARCH, 0, 32'h5a5a_5a5a, 0);
		send_request(idq_pkg::REQ_TAKE, 0, '0, 64);
		send_request(idq_pkg::REQ_PUSH_BACK, 0, 32'd3, 0);
		send_request(idq_pkg::REQ_TAKE, 0, '0, 2);
		send_request(idq_pkg::REQ_POP_FRONT, 0, '0, 0);

		for (i = 0; i < 204; i++) begin
			item_index = i;
			steady = (i >= 120 && i < 170);
			filling = ((i / 40) % 2 == 0);
			pick = $urandom_range(0, 99);
			if (pick < 12)
				kind = idq_pkg::REQ_SEARCH;
			else if (pick < 24)
				kind = idq_pkg::REQ_READ;
			else if (pick < 34)
				kind = idq_pkg::REQ_WRITE;
			else if (pick < (filling ? 52 : 42))
				kind = idq_pkg::REQ_PUSH_FRONT;
			else if (pick < (filling ? 72 : 50))
				kind = idq_pkg::REQ_PUSH_BACK;
			else if (pick < (filling ? 84 : 56))
				kind = idq_pkg::REQ_COPY;
			else if (pick < (filling ? 90 : 76))
				kind = idq_pkg::REQ_POP_FRONT;
			else
				kind = idq_pkg::REQ_TAKE;

			// small values so searches hit often
			case ($urandom_range(0, 5))
				0, 1: val = $urandom;
				2: begin
					case ($urandom_range(0, 3))
						0: val = 32'h8000_0000;
						1: val = 32'h7fff_ffff;
						2: val = 32'hffff_ffff;
						default: val = '0;
					endcase
				end
				default: val = $urandom_range(0, 15);
			endcase

			if (fill_level > 0 && $urandom_range(0, 4) != 0)
				pos = $urandom_range(0, fill_level - 1);
			else
				pos = $urandom_range(0, 63);

			room = idq_pkg::CAPACITY - fill_level;
			pick = $urandom_range(0, 9);
			if (kind == idq_pkg::REQ_COPY) begin
				if (pick == 0)
					n = $urandom_range(0, 64);
				else if (pick == 1)
					n = room;
				else
					n = (room > 0) ? $urandom_range(1, (room < 8) ? room : 8) : 1;
			end else begin
				if (pick == 0)
					n = $urandom_range(0, 64);
				else if (pick == 1)
					n = fill_level;
				else
					n = (fill_level > 0) ? $urandom_range(1, (fill_level < 8) ? fill_level : 8) : 1;
			end

			send_request(kind, pos, val, n);
		end

		steady = 1'b0;
		req.valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
